[design/bis_pkg.sv]
package bis_pkg;

  // Width of one sorted value.
  localparam int VALUE_W = 31;

  // Default capacity of the batch store.
  localparam int DEF_MAX_ITEMS = 64;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // Store port strobes from the sequencer.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[design/batch_integer_sorter.sv]
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    value[30:0], last_in
// result    out        out_valid / out_stall  sorted_value[30:0], last_out, overflow
//
// An input transaction runs a binary search over the n held values, shifts the tail up
// one entry at a time from the end down to the insertion slot p, and writes the new value;
// the search takes s steps, at most ceil(log2(n+1)). The search and the shift both go
// through the single read port of the store. A transaction that finds the store full is
// dropped in its accepting cycle. A transaction marked last then streams the batch out,
// each result read from the store and then loaded into the result register.
// Reset is synchronous and empties the batch; the store contents are not cleared.
// A stalled result holds in its register; input is stalled until the final result of
// the batch is loaded into that register.
module batch_integer_sorter
  import bis_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               last_out,
  output logic               overflow
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // Port between the sequencer and the sorted store.
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // The sequencer runs the binary search with one shared comparator, shifts the
  // tail up one entry at a time, writes the new value, and streams the batch out.
  bis_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last_in      (last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow),
    .mem_ctl      (mem_ctl),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // The store keeps the held values in ascending order; the read is registered.
  bis_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[design/bis_store.sv]
module bis_store
  import bis_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ITEMS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/bis_ctrl.sv]
module bis_ctrl
  import bis_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int AW        = $clog2(MAX_ITEMS),
  parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] sorted_value,
  output logic               last_out,
  output logic               overflow,
  output mem_ctl_t           mem_ctl,
  output logic [AW-1:0]      mem_waddr,
  output logic [VALUE_W-1:0] mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [VALUE_W-1:0] mem_rdata
);

  localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

  state_t             state, state_next;
  logic [CW-1:0]      held;
  logic               dropped;
  logic [VALUE_W-1:0] val;
  logic               last;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      k;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      idx_dec;
  logic               accept;
  logic               full;
  logic               not_greater;
  logic               emit_go;
  logic               emit_done;

  assign mid         = lo + ((hi - lo) >> 1);
  assign idx_dec     = idx - CW'(1);
  assign accept      = in_valid && (state == S_IDLE);
  assign full        = (held >= FULL);
  // The one shared comparator: stored entry against the new value.
  assign not_greater = (mem_rdata <= val);
  assign emit_go     = !out_valid || !out_stall;
  assign emit_done   = ((k + CW'(1)) == held);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (full) begin
            state_next = last_in ? S_EMIT_RD : S_IDLE;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (lo < hi) begin
          state_next = S_COMPARE;
        end else if (idx > lo) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_COMPARE:  state_next = S_SEARCH;
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (idx_dec > lo) ? S_SHIFT_RD : S_INSERT;
      S_INSERT:   state_next = last ? S_EMIT_RD : S_IDLE;
      S_EMIT_RD:  state_next = emit_go ? S_EMIT_LD : S_EMIT_RD;
      S_EMIT_LD:  state_next = emit_done ? S_IDLE : S_EMIT_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    mem_waddr     = lo[AW-1:0];
    mem_wdata     = val;
    mem_raddr     = mid[AW-1:0];
    case (state)
      S_SEARCH: begin
        mem_ctl.rd_en = (lo < hi);
        mem_raddr     = mid[AW-1:0];
      end
      S_SHIFT_RD: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = idx_dec[AW-1:0];
      end
      S_SHIFT_WR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = idx[AW-1:0];
        mem_wdata     = mem_rdata;
      end
      S_INSERT: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = lo[AW-1:0];
        mem_wdata     = val;
      end
      S_EMIT_RD: begin
        mem_ctl.rd_en = emit_go;
        mem_raddr     = k[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      held    <= '0;
      dropped <= 1'b0;
      k       <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && full) begin
            dropped <= 1'b1;
          end
        end
        S_INSERT: held <= held + CW'(1);
        S_EMIT_LD: begin
          if (emit_done) begin
            held    <= '0;
            dropped <= 1'b0;
            k       <= '0;
          end else begin
            k <= k + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          val  <= value;
          last <= last_in;
          lo   <= '0;
          hi   <= held;
          idx  <= held;
        end
      end
      S_COMPARE: begin
        if (not_greater) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      S_SHIFT_WR: idx <= idx_dec;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT_LD) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT_LD) begin
      sorted_value <= mem_rdata;
      last_out     <= emit_done;
      overflow     <= dropped;
    end
  end

  a_held_bounded: assert property (@(posedge clk) disable iff (rst)
    held <= FULL)
    else $error("held count exceeds capacity");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH || state == S_COMPARE) |-> (lo <= hi && hi <= held))
    else $error("search window out of order");

  a_batch_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_LD && emit_done) |=> (state == S_IDLE && held == '0 && !dropped))
    else $error("batch not emptied after final result");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (state == S_IDLE && held == '0 && !out_valid))
    else $error("reset did not clear control state");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_LD) |-> !out_valid)
    else $error("result register overwritten");

endmodule
